// ----- rtl/msn_pkg.sv -----
// shared constants, codes and table functions for the sine note voice
`timescale 1ns / 1ps
`default_nettype none

package msn_pkg;

  // default geometry
  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int PITCH_W = 7;
  localparam int VEL_W   = 16;
  localparam int BASE_W  = 31;
  localparam int MAG_W   = 31;  // sine magnitude, Q1.30, up to 1.0

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

  localparam logic [63:0] BASE_RESET  = 64'd39370534;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // 2^(semi/12) in Q1.30
  function automatic logic [BASE_W-1:0] semitone_q30(input logic [3:0] semi);
    logic [BASE_W-1:0] val;
    case (semi)
      4'd0:    val = 31'd1073741824;
      4'd1:    val = 31'd1137589835;
      4'd2:    val = 31'd1205234447;
      4'd3:    val = 31'd1276901417;
      4'd4:    val = 31'd1352829926;
      4'd5:    val = 31'd1433273380;
      4'd6:    val = 31'd1518500250;
      4'd7:    val = 31'd1608794974;
      4'd8:    val = 31'd1704458901;
      4'd9:    val = 31'd1805811301;
      4'd10:   val = 31'd1913190429;
      4'd11:   val = 31'd2026954652;
      default: val = '0;
    endcase
    return val;
  endfunction

  // sin(x) for x in [0, pi/2], Q2.30, odd series to x^11 in horner form
  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    return (t > ONE_Q30) ? ONE_Q30 : t;
  endfunction

  // sine magnitude for one table address, quadrant folded in
  function automatic logic [63:0] sine_mag(input logic [63:0] addr, input int abits);
    logic [63:0] qlen;
    logic [63:0] quad;
    logic [63:0] r;
    qlen = 64'd1 << (abits - 2);
    quad = (addr >> (abits - 2)) & 64'd3;
    r    = addr & (qlen - 64'd1);
    if (quad[0]) begin
      r = qlen - r;
    end
    return quarter_sine((r * HALF_PI_Q30) >> (abits - 2));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/msn_if.sv -----
// valid/ready channel interfaces for note events and output samples
`timescale 1ns / 1ps
`default_nettype none

interface msn_in_if;
  logic                        valid;
  logic                        ready;
  logic [msn_pkg::CMD_W-1:0]   cmd;
  logic [msn_pkg::PITCH_W-1:0] pitch;
  logic [msn_pkg::VEL_W-1:0]   velocity;

  modport source (output valid, cmd, pitch, velocity, input ready);
  modport sink   (input valid, cmd, pitch, velocity, output ready);
endinterface

interface msn_out_if #(
  parameter int SAMPLE_BITS = msn_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/mono_sine_note_voice_top.sv -----
// monophonic sine voice: note events in, q1.15 samples out
`timescale 1ns / 1ps
`default_nettype none

// Monophonic sine voice. Each beat on in_ch is a sample tick, a note on or a
// note off; only a tick returns a beat on out_ch, which carries
// sin(2*pi*phase) * gain as a signed fraction of SAMPLE_BITS bits. A note on
// with nonzero velocity retunes the voice to base_increment * 2^((pitch-69)/12)
// (rounded, saturated to 2^(PHASE_BITS-1)-1), latches the velocity as gain and
// opens the gate; a note off closes it. With the gate closed a tick returns 0
// and the phase holds. cfg_wdata is the phase step of note 69 and only
// affects later note ons. The block takes one beat per clock while in_ch is
// ready: a tick's sample passes the sine rom read, gain multiply and full-scale
// multiply and clamp, each registered; the stages close up bubbles so in_ch only
// stalls when out_ch is backed up all the way. A note on's step goes through a
// multiply register, then rounds into step_r; the path always drains and is
// forwarded to a tick taken right behind it. The sine table is a synchronous rom
// of 2^SINE_ADDR_BITS entries; there is no clearing pass after reset.
module mono_sine_note_voice_top #(
  parameter int PHASE_BITS     = msn_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = msn_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = msn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  msn_in_if.sink                          in_ch,
  msn_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [msn_pkg::BASE_W-1:0] cfg_wdata
);

  localparam int SINE_DEPTH = 2 ** SINE_ADDR_BITS;
  localparam int MAG_W      = msn_pkg::MAG_W;
  localparam int VEL_W      = msn_pkg::VEL_W;
  localparam int BASE_W     = msn_pkg::BASE_W;
  localparam int PROD_W     = 2 * BASE_W;
  localparam int GPROD_W    = MAG_W + VEL_W;
  localparam int FS_W       = SAMPLE_BITS - 1;
  localparam int VP_W       = MAG_W + FS_W;
  localparam logic [63:0] STEP_MAX   = (64'd1 << (PHASE_BITS - 1)) - 64'd1;
  localparam logic [FS_W-1:0] FULL_SCALE = {FS_W{1'b1}};

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int a = 0; a < SINE_DEPTH; a++) begin
      rom[a] = MAG_W'(msn_pkg::sine_mag(64'(a), SINE_ADDR_BITS));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // voice state
  logic [BASE_W-1:0]     base_r;
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [VEL_W-1:0]      gain_r;
  logic                  gate_r;

  // note-on step path: multiply, then round/shift/saturate
  logic                  stepb_v_r;
  logic [PROD_W-1:0]     prod_r;
  logic [5:0]            sh_r;

  // sample pipeline
  logic                  s1_v_r;
  logic                  s1_neg_r;
  logic [VEL_W-1:0]      s1_gain_r;
  logic [MAG_W-1:0]      rom_q_r;
  logic                  s2_v_r;
  logic                  s2_neg_r;
  logic [MAG_W-1:0]      s2_scaled_r;
  logic                  out_v_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  // handshake and stage enables, bubbles collapse
  logic en_out, en_s2, en_s1;
  logic acc, is_tick, is_on, is_off;

  assign en_out = !out_v_r || out_ch.ready;
  assign en_s2  = !s2_v_r || en_out;
  assign en_s1  = !s1_v_r || en_s2;

  assign in_ch.ready = en_s1;
  assign acc     = in_ch.valid && en_s1;
  assign is_tick = acc && (in_ch.cmd == msn_pkg::CMD_TICK);
  assign is_on   = acc && (in_ch.cmd == msn_pkg::CMD_NOTE_ON) && (in_ch.velocity != '0);
  assign is_off  = acc && (in_ch.cmd == msn_pkg::CMD_NOTE_OFF);

  // note index counted from three semitones below pitch 0, split into octave and semitone
  logic [7:0]        idx;
  logic [15:0]       idx_m;
  logic [3:0]        oct;
  logic [3:0]        semi;
  logic [PROD_W-1:0] prod_nxt;

  assign idx   = {1'b0, in_ch.pitch} + 8'd3;
  assign idx_m = 16'(idx) * 16'd171;       // idx / 12 for idx below 192
  assign oct   = idx_m[14:11];
  assign semi  = 4'(idx - 8'(oct) * 8'd12);
  assign prod_nxt = PROD_W'(base_r) * PROD_W'(msn_pkg::semitone_q30(semi));

  // round to nearest at the octave shift, then saturate
  logic [PROD_W:0]       rnd;
  logic [PROD_W:0]       rsum;
  logic [63:0]           s64;
  logic [PHASE_BITS-1:0] step_nxt;
  logic [PHASE_BITS-1:0] step_eff;
  logic [PHASE_BITS-1:0] phase_nxt;

  assign rnd      = (PROD_W + 1)'(1) << (sh_r - 6'd1);
  assign rsum     = {1'b0, prod_r} + rnd;
  assign s64      = 64'(rsum >> sh_r);
  assign step_nxt = (s64 > STEP_MAX) ? PHASE_BITS'(STEP_MAX) : PHASE_BITS'(s64);
  // a tick right behind a note on sees the new step
  assign step_eff  = stepb_v_r ? step_nxt : step_r;
  assign phase_nxt = phase_acc_r + step_eff;

  logic [SINE_ADDR_BITS-1:0] addr;
  assign addr = phase_acc_r[PHASE_BITS-1 -: SINE_ADDR_BITS];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_W'(msn_pkg::BASE_RESET);
      phase_acc_r <= '0;
      step_r      <= PHASE_BITS'(msn_pkg::BASE_RESET);
      gain_r      <= '0;
      gate_r      <= 1'b0;
      stepb_v_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      stepb_v_r <= is_on;
      if (stepb_v_r) begin
        step_r <= step_nxt;
      end
      if (is_on) begin
        gain_r <= in_ch.velocity;
        gate_r <= 1'b1;
      end else if (is_off) begin
        gate_r <= 1'b0;
      end
      if (is_tick && gate_r) begin
        phase_acc_r <= phase_nxt;
      end
      if (en_s1) begin
        s1_v_r <= is_tick;
      end
      if (en_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // note-on multiply stage
  always_ff @(posedge clk) begin
    if (is_on) begin
      prod_r <= prod_nxt;
      sh_r   <= 6'd36 - 6'(oct);
    end
  end

  // sine rom, registered read
  always_ff @(posedge clk) begin
    if (en_s1) begin
      rom_q_r   <= SINE_ROM[addr];
      s1_neg_r  <= addr[SINE_ADDR_BITS-1];
      s1_gain_r <= gate_r ? gain_r : '0;  // closed gate gives zero
    end
  end

  // gain multiply
  logic [GPROD_W-1:0] gprod;
  assign gprod = GPROD_W'(rom_q_r) * GPROD_W'(s1_gain_r);

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_scaled_r <= gprod[GPROD_W-1 -: MAG_W];
      s2_neg_r    <= s1_neg_r;
    end
  end

  // full-scale multiply, round, clamp and sign
  logic [VP_W-1:0]        vprod;
  logic [VP_W:0]          vround;
  logic [SAMPLE_BITS:0]   vmag;
  logic [SAMPLE_BITS-1:0] vclamp;
  logic [SAMPLE_BITS-1:0] sample_nxt;

  assign vprod      = VP_W'(s2_scaled_r) * VP_W'(FULL_SCALE);
  assign vround     = {1'b0, vprod} + ((VP_W + 1)'(1) << 29);
  assign vmag       = vround[VP_W:30];
  assign vclamp     = (vmag > (SAMPLE_BITS + 1)'(FULL_SCALE)) ?
                      SAMPLE_BITS'(FULL_SCALE) : SAMPLE_BITS'(vmag);
  assign sample_nxt = s2_neg_r ? (SAMPLE_BITS'(0) - vclamp) : vclamp;

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.sample = out_sample_r;

`ifndef NO_ASSERTIONS
  // a live note on always enters the step path next cycle
  a_step_follows: assert property (@(posedge clk) disable iff (!rst_n)
    is_on |=> stepb_v_r)
    else $error("note on did not enter step path");

  // closed gate: a tick leaves the phase alone
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && !gate_r && !(is_on)) |=> $stable(phase_acc_r))
    else $error("phase moved with gate closed");

  // zero gain through the multiply gives zero
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (en_s2 && s1_v_r && (s1_gain_r == '0)) |=> (s2_scaled_r == '0))
    else $error("zero gain gave nonzero product");

  // clamp keeps the most negative code out
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_sample_r != {1'b1, {(SAMPLE_BITS - 1){1'b0}}}))
    else $error("sample outside symmetric range");

  // input only stalls behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en_s1 |-> (out_v_r && !out_ch.ready && s2_v_r && s1_v_r))
    else $error("input stalled with room in pipeline");
`endif

endmodule

`default_nettype wire
